/* sv/tvd_pkg.sv */
package tvd_pkg;

  // Field and register widths.
  localparam int SAMPLE_W  = 24;
  localparam int CH_W      = 3;
  localparam int MIDI_CH_W = 4;
  localparam int NOTE_W    = 7;
  localparam int VEL_W     = 7;
  localparam int LEVEL_W   = 23;
  localparam int WIN_W     = 16;
  localparam int REL_W     = 20;
  localparam int MAG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 23;

  // Number of input channels that carry state.
  localparam int CHANNELS = 8;

  // Serial divider widths: the dividend is 126 times a 24-bit difference.
  localparam int NUM_W = 31;
  localparam int DEN_W = LEVEL_W;
  localparam int CNT_W = $clog2(NUM_W);

  // Full-scale values of the two sample formats.
  localparam logic [LEVEL_W-1:0] FULL24 = 23'h7FFFFF;
  localparam logic [LEVEL_W-1:0] FULL16 = 23'h007FFF;

  // Velocity limits.
  localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;
  localparam logic [VEL_W-1:0] VEL_MIN = 7'd1;
  localparam logic [VEL_W-1:0] VEL_OFF = 7'd0;
  localparam logic [NUM_W-1:0] QUO_SAT = 31'd126;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRIGGER_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_NUMBER    = 3'd5;

  // Configuration reset values.
  localparam logic [LEVEL_W-1:0] TRIGGER_LEVEL_RST = 23'd262143;
  localparam logic [WIN_W-1:0]   PEAK_WINDOW_RST   = 16'd0;
  localparam logic [WIN_W-1:0]   RETRIG_WAIT_RST   = 16'd0;
  localparam logic [REL_W-1:0]   RELEASE_DELAY_RST = 20'd11025;
  localparam logic               SAMPLE_FORMAT_RST = 1'b0;
  localparam logic [NOTE_W-1:0]  NOTE_NUMBER_RST   = 7'd60;

  // Sample format codes.
  localparam logic FMT_24BIT = 1'b0;
  localparam logic FMT_16BIT = 1'b1;

  // Event kind codes.
  localparam logic EV_NOTE_OFF = 1'b0;
  localparam logic EV_NOTE_ON  = 1'b1;

  // Per-channel phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PEAK = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_UPDATE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_VEL,
    ST_EMIT
  } state_t;

  // Result of one channel state update.
  typedef struct packed {
    logic             note_on;
    logic             note_off;
    logic [MAG_W-1:0] peak;
  } upd_t;

endpackage

/* sv/tvd_serial_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module tvd_serial_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tvd_pkg::NUM_W-1:0] num,
  input  logic [tvd_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [tvd_pkg::NUM_W-1:0] quotient
);
  import tvd_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  always_comb begin
    trial = {rem, acc[NUM_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

  assign quotient = acc;

endmodule

/* sv/tvd_chan_state.sv */
// Per-channel trigger state: phase, window counter, peak and release counter.
module tvd_chan_state (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        update,
  input  logic [tvd_pkg::CH_W-1:0]    ch,
  input  logic [tvd_pkg::MAG_W-1:0]   mag,
  input  logic [tvd_pkg::LEVEL_W-1:0] trigger_level,
  input  logic [tvd_pkg::WIN_W-1:0]   peak_window,
  input  logic [tvd_pkg::WIN_W-1:0]   retrigger_wait,
  input  logic [tvd_pkg::REL_W-1:0]   release_delay,
  output tvd_pkg::upd_t               upd
);
  import tvd_pkg::*;

  phase_t           phase    [CHANNELS];
  logic [WIN_W-1:0] win_cnt  [CHANNELS];
  logic [MAG_W-1:0] peak_mag [CHANNELS];
  logic [REL_W-1:0] rel_cnt  [CHANNELS];

  phase_t           phase_next;
  logic [WIN_W-1:0] win_next;
  logic [MAG_W-1:0] peak_next;
  logic [REL_W-1:0] rel_next;
  logic [WIN_W-1:0] win_dec;
  logic [REL_W-1:0] rel_dec;
  logic [MAG_W-1:0] trig_ext;
  logic             note_on;
  logic             note_off;

  assign trig_ext = {1'b0, trigger_level};
  assign win_dec  = win_cnt[ch] - 1'b1;
  assign rel_dec  = rel_cnt[ch] - 1'b1;

  // Next phase, window and peak of the addressed channel.
  always_comb begin
    phase_next = phase[ch];
    win_next   = win_cnt[ch];
    peak_next  = peak_mag[ch];
    note_on    = 1'b0;
    case (phase[ch])
      PH_PEAK: begin
        if (mag > peak_mag[ch]) begin
          peak_next = mag;
        end
        win_next = win_dec;
        note_on  = (win_dec == '0);
      end
      PH_WAIT: begin
        win_next = win_dec;
        if (win_dec == '0) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (mag > trig_ext) begin
          phase_next = PH_PEAK;
          peak_next  = trig_ext;
          win_next   = peak_window;
          note_on    = (peak_window == '0);
        end
      end
    endcase
    if (note_on) begin
      win_next   = retrigger_wait;
      phase_next = (retrigger_wait == '0) ? PH_IDLE : PH_WAIT;
    end
  end

  // Release countdown; a note-on reloads it without counting.
  always_comb begin
    rel_next = rel_cnt[ch];
    note_off = 1'b0;
    if (note_on) begin
      rel_next = release_delay;
    end else if (rel_cnt[ch] != '0) begin
      rel_next = rel_dec;
      note_off = (rel_dec == '0);
    end
  end

  // State arrays.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase[i]    <= PH_IDLE;
        win_cnt[i]  <= '0;
        peak_mag[i] <= '0;
        rel_cnt[i]  <= '0;
      end
    end else if (update) begin
      phase[ch]    <= phase_next;
      win_cnt[ch]  <= win_next;
      peak_mag[ch] <= peak_next;
      rel_cnt[ch]  <= rel_next;
    end
  end

  assign upd.note_on  = note_on;
  assign upd.note_off = note_off;
  assign upd.peak     = peak_next;

endmodule

/* sv/tap_trigger_velocity_detector_core.sv */
// A sample goes through the magnitude and update states. A note-off adds emit;
// a note-on adds prepare, multiply, divide, velocity and emit, with prepare going
// straight to emit if the velocity saturates. No new sample is taken until the
// last is through, so a note-on holds the input for the 31-step serial divider.
// Reset (synchronous, active high) sets every channel idle with no note pending
// and loads the configuration defaults; no clearing pass is needed.
module tap_trigger_velocity_detector_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tvd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic signed [tvd_pkg::SAMPLE_W-1:0] sample,
  input  logic [tvd_pkg::CH_W-1:0]        channel,
  output logic                            event_valid,
  input  logic                            event_ready,
  output logic                            event_kind,
  output logic [tvd_pkg::MIDI_CH_W-1:0]   event_channel,
  output logic [tvd_pkg::NOTE_W-1:0]      note,
  output logic [tvd_pkg::VEL_W-1:0]       velocity
);
  import tvd_pkg::*;

  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

  // Configuration registers.
  logic [LEVEL_W-1:0] trigger_level;
  logic [WIN_W-1:0]   peak_window;
  logic [WIN_W-1:0]   retrigger_wait;
  logic [REL_W-1:0]   release_delay;
  logic               sample_format;
  logic [NOTE_W-1:0]  note_number;

  state_t state;
  state_t state_next;

  logic [SAMPLE_W-1:0] smp;
  logic [CH_W-1:0]     ch;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    mag_next;
  logic [MAG_W-1:0]    pk;
  logic [MAG_W-1:0]    diff;
  logic [DEN_W-1:0]    den;
  logic [VEL_W-1:0]    vel;
  logic                kind;
  logic                sat_full;
  logic                sat_low;
  logic [LEVEL_W-1:0]  full_scale;
  logic [NUM_W-1:0]    num;
  logic [NUM_W-1:0]    quotient;
  logic                div_start;
  logic                div_done;
  logic                upd_en;
  logic                emit;
  logic                in_range;
  upd_t                upd;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level  <= TRIGGER_LEVEL_RST;
      peak_window    <= PEAK_WINDOW_RST;
      retrigger_wait <= RETRIG_WAIT_RST;
      release_delay  <= RELEASE_DELAY_RST;
      sample_format  <= SAMPLE_FORMAT_RST;
      note_number    <= NOTE_NUMBER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRIGGER_LEVEL:  trigger_level  <= cfg_data[LEVEL_W-1:0];
        REG_PEAK_WINDOW:    peak_window    <= cfg_data[WIN_W-1:0];
        REG_RETRIGGER_WAIT: retrigger_wait <= cfg_data[WIN_W-1:0];
        REG_RELEASE_DELAY:  release_delay  <= cfg_data[REL_W-1:0];
        REG_SAMPLE_FORMAT:  sample_format  <= cfg_data[0];
        REG_NOTE_NUMBER:    note_number    <= cfg_data[NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude of the captured sample in the selected format.
  always_comb begin
    if (sample_format == FMT_16BIT) begin
      mag_next = smp[15] ? MAG_W'(16'(-smp[15:0])) : MAG_W'(smp[15:0]);
    end else begin
      mag_next = smp[SAMPLE_W-1] ? MAG_W'(-smp) : smp;
    end
  end

  assign full_scale = (sample_format == FMT_16BIT) ? FULL16 : FULL24;
  assign in_range   = {1'b0, ch} < CH_LIMIT;

  // 126 times the difference, as a shift and a subtract.
  assign num = {diff, 7'b0} - {6'b0, diff, 1'b0};

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        state_next = in_range ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: begin
        if (upd.note_on) begin
          state_next = ST_PREP;
        end else if (upd.note_off) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PREP: begin
        state_next = (sat_full || sat_low) ? ST_EMIT : ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_VEL;
        end
      end
      ST_VEL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!event_valid || event_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sample_ready = (state == ST_IDLE);
    upd_en       = (state == ST_UPDATE);
    div_start    = (state == ST_MUL);
    emit         = (state == ST_EMIT) && (!event_valid || event_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Special cases of the velocity: level at or above full scale and peak not above level.
  assign sat_full = full_scale <= trigger_level;
  assign sat_low  = pk <= {1'b0, trigger_level};

  // Working registers of one sample.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      smp <= sample;
      ch  <= channel;
    end
    if (state == ST_MAG) begin
      mag <= mag_next;
    end
    if (state == ST_UPDATE) begin
      pk   <= upd.peak;
      kind <= upd.note_on ? EV_NOTE_ON : EV_NOTE_OFF;
      vel  <= VEL_OFF;
    end
    if (state == ST_PREP) begin
      diff <= pk - {1'b0, trigger_level};
      den  <= full_scale - trigger_level;
      if (sat_full) begin
        vel <= VEL_MAX;
      end else if (sat_low) begin
        vel <= VEL_MIN;
      end
    end
    if (state == ST_VEL) begin
      vel <= (quotient >= QUO_SAT) ? VEL_MAX : VEL_W'(quotient[VEL_W-1:0] + 1'b1);
    end
  end

  // Output register; it is reloaded in the same cycle its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (emit) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind    <= kind;
      event_channel <= MIDI_CH_W'(ch);
      note          <= note_number;
      velocity      <= vel;
    end
  end

  tvd_chan_state u_chan_state (
    .clk            (clk),
    .rst            (rst),
    .update         (upd_en),
    .ch             (ch),
    .mag            (mag),
    .trigger_level  (trigger_level),
    .peak_window    (peak_window),
    .retrigger_wait (retrigger_wait),
    .release_delay  (release_delay),
    .upd            (upd)
  );

  tvd_serial_div u_serial_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (den),
    .done     (div_done),
    .quotient (quotient)
  );

`ifndef ASSERT_OFF
  a_note_on_vel: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == EV_NOTE_ON) |-> velocity != VEL_OFF)
    else $error("note-on with zero velocity");

  a_note_off_vel: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == EV_NOTE_OFF) |-> velocity == VEL_OFF)
    else $error("note-off with nonzero velocity");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> state == ST_MAG)
    else $error("sample transfer did not start processing");
`endif

endmodule
